// ===== hdl/mfmd_pkg.sv =====
// shared types and constants for the multi-turn feedback decoder
`default_nettype none
package mfmd_pkg;

   // encoder geometry
   localparam int ANGLE_W          = 13;
   localparam int COUNTS_PER_TURN  = 8192;
   localparam int HALF_TURN        = COUNTS_PER_TURN / 2;
   localparam int DELTA_W          = ANGLE_W + 2;

   // field widths
   localparam int WORD_W   = 32;
   localparam int RAW_W    = 16;
   localparam int TEMP_W   = 8;
   localparam int POS_W    = 39;
   localparam int OFFSET_W = 17;
   localparam int POS_PROD_W = 2 * WORD_W;
   localparam int RAW_PROD_W = RAW_W + WORD_W;
   localparam int FRAC_W     = 16;

   // register map
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] REG_COUNT_OFFSET   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_POSITION_GAIN  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SPEED_GAIN     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TORQUE_GAIN    = 2'd3;

   // one unwrapped report waiting for scaling
   typedef struct packed {
      logic signed [WORD_W-1:0] total_count;
      logic signed [WORD_W-1:0] turn_count;
      logic signed [RAW_W-1:0]  speed_rpm;
      logic signed [RAW_W-1:0]  current_raw;
      logic [TEMP_W-1:0]        temperature;
   } entry_type;

   // queue occupancy flags
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // scaling gains handed to the back end
   typedef struct packed {
      logic [WORD_W-1:0] position_gain;
      logic [WORD_W-1:0] speed_gain;
      logic [WORD_W-1:0] torque_gain;
   } gains_type;

endpackage
`default_nettype wire

// ===== hdl/mfmd_if.sv =====
// valid/ready channel interfaces for feedback reports and decoded results
`default_nettype none
interface mfmd_req_if;
   logic                      valid;
   logic                      ready;
   logic [12:0]               rotor_angle;
   logic signed [15:0]        speed_rpm;
   logic signed [15:0]        current_raw;
   logic [7:0]                temperature_in;

   modport source (output valid, rotor_angle, speed_rpm, current_raw, temperature_in,
                   input ready);
   modport sink   (input valid, rotor_angle, speed_rpm, current_raw, temperature_in,
                   output ready);
endinterface

interface mfmd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic signed [31:0]        total_count;
   logic signed [31:0]        turn_count;
   logic signed [38:0]        position_fix;
   logic signed [31:0]        speed_fix;
   logic signed [31:0]        torque_fix;
   logic [7:0]                temperature_out;

   modport source (output valid, total_count, turn_count, position_fix, speed_fix,
                   torque_fix, temperature_out, input ready);
   modport sink   (input valid, total_count, turn_count, position_fix, speed_fix,
                   torque_fix, temperature_out, output ready);
endinterface
`default_nettype wire

// ===== hdl/mfmd_front.sv =====
// front end: takes reports, tracks turns and forms the total count
`default_nettype none
module mfmd_front (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   mfmd_req_if.sink                                     req_chan,
   input  wire logic signed [mfmd_pkg::OFFSET_W-1:0]    count_offset,
   input  wire mfmd_pkg::queue_status_type              q_status,
   output logic                                         push,
   output mfmd_pkg::entry_type                          push_entry
);

   logic [mfmd_pkg::ANGLE_W-1:0]      prev_angle_ff, prev_angle_in;
   logic [mfmd_pkg::WORD_W-1:0]       turns_ff, turns_in;
   logic signed [mfmd_pkg::DELTA_W-1:0] delta;
   logic [mfmd_pkg::WORD_W-1:0]       total;

   // accept a word whenever the queue has room
   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && req_chan.ready;

   // angle jump against the previous report
   assign delta = $signed({2'b00, req_chan.rotor_angle}) - $signed({2'b00, prev_angle_ff});

   // unwrap: big negative jump is a forward turn, big positive jump a backward one
   always_comb begin
      turns_in      = turns_ff;
      prev_angle_in = prev_angle_ff;
      if (push) begin
         prev_angle_in = req_chan.rotor_angle;
         if (delta < -mfmd_pkg::DELTA_W'(mfmd_pkg::HALF_TURN)) begin
            turns_in = turns_ff + 32'd1;
         end else if (delta > mfmd_pkg::DELTA_W'(mfmd_pkg::HALF_TURN)) begin
            turns_in = turns_ff - 32'd1;
         end
      end
   end

   // total count wraps in 32 bits
   assign total = turns_in * mfmd_pkg::WORD_W'(mfmd_pkg::COUNTS_PER_TURN)
                + {{(mfmd_pkg::WORD_W - mfmd_pkg::ANGLE_W){1'b0}}, req_chan.rotor_angle}
                + {{(mfmd_pkg::WORD_W - mfmd_pkg::OFFSET_W){count_offset[mfmd_pkg::OFFSET_W-1]}},
                   count_offset};

   always_comb begin
      push_entry.total_count = $signed(total);
      push_entry.turn_count  = $signed(turns_in);
      push_entry.speed_rpm   = req_chan.speed_rpm;
      push_entry.current_raw = req_chan.current_raw;
      push_entry.temperature = req_chan.temperature_in;
   end

   // turn state
   always_ff @(posedge clock) begin
      if (reset) begin
         turns_ff      <= '0;
         prev_angle_ff <= '0;
      end else begin
         turns_ff      <= turns_in;
         prev_angle_ff <= prev_angle_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/mfmd_queue.sv =====
// short fifo between the front end and the scaling back end
`default_nettype none
module mfmd_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire mfmd_pkg::entry_type          push_entry,
   input  wire logic                         pop,
   output mfmd_pkg::entry_type               pop_entry,
   output mfmd_pkg::queue_status_type        q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mfmd_pkg::entry_type  slots_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   // pointer advance with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_entry      = slots_ff[rd_ptr_ff];

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/mfmd_back.sv =====
// back end: gain products, then shift, saturate and hold the result word
`default_nettype none
module mfmd_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire mfmd_pkg::queue_status_type   q_status,
   input  wire mfmd_pkg::entry_type          pop_entry,
   input  wire mfmd_pkg::gains_type          gains,
   output logic                              pop,
   mfmd_rsp_if.source                        rsp_chan
);

   localparam int POS_SHIFT_W = mfmd_pkg::POS_PROD_W - mfmd_pkg::FRAC_W;
   localparam int POS_W       = mfmd_pkg::POS_W;

   // product stage
   logic                                        s1_valid_ff, s1_valid_in;
   logic signed [mfmd_pkg::WORD_W-1:0]          s1_total_ff, s1_turns_ff;
   logic [mfmd_pkg::TEMP_W-1:0]                 s1_temp_ff;
   logic signed [mfmd_pkg::POS_PROD_W-1:0]      s1_pos_prod_ff, s1_pos_prod_in;
   logic signed [mfmd_pkg::RAW_PROD_W-1:0]      s1_spd_prod_ff, s1_spd_prod_in;
   logic signed [mfmd_pkg::RAW_PROD_W-1:0]      s1_trq_prod_ff, s1_trq_prod_in;
   logic                                        s1_en;

   // output stage
   logic                                        out_valid_ff, out_valid_in;
   logic                                        out_en;
   logic signed [POS_SHIFT_W-1:0]               pos_shift;
   logic                                        pos_ovf;
   logic signed [POS_W-1:0]                     pos_sat;

   // stall chain: a stage moves when it is empty or the next one moves
   assign out_en = !out_valid_ff || rsp_chan.ready;
   assign s1_en  = !s1_valid_ff || out_en;
   assign pop    = !q_status.empty && s1_en;

   always_comb begin
      s1_valid_in  = s1_en ? pop : s1_valid_ff;
      out_valid_in = out_en ? s1_valid_ff : out_valid_ff;
   end

   // signed values times unsigned q16.16 gains
   assign s1_pos_prod_in = pop_entry.total_count * $signed({1'b0, gains.position_gain});
   assign s1_spd_prod_in = pop_entry.speed_rpm * $signed({1'b0, gains.speed_gain});
   assign s1_trq_prod_in = pop_entry.current_raw * $signed({1'b0, gains.torque_gain});

   // drop sixteen fraction bits (floor) and clamp position to its field
   assign pos_shift = s1_pos_prod_ff[mfmd_pkg::POS_PROD_W-1:mfmd_pkg::FRAC_W];
   assign pos_ovf   = (pos_shift[POS_SHIFT_W-1:POS_W-1] != {(POS_SHIFT_W - POS_W + 1){1'b0}})
                   && (pos_shift[POS_SHIFT_W-1:POS_W-1] != {(POS_SHIFT_W - POS_W + 1){1'b1}});

   always_comb begin
      if (!pos_ovf) begin
         pos_sat = pos_shift[POS_W-1:0];
      end else if (pos_shift[POS_SHIFT_W-1]) begin
         pos_sat = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         pos_sat = {1'b0, {(POS_W-1){1'b1}}};
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // product registers
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_total_ff    <= pop_entry.total_count;
         s1_turns_ff    <= pop_entry.turn_count;
         s1_temp_ff     <= pop_entry.temperature;
         s1_pos_prod_ff <= s1_pos_prod_in;
         s1_spd_prod_ff <= s1_spd_prod_in;
         s1_trq_prod_ff <= s1_trq_prod_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (out_en && s1_valid_ff) begin
         rsp_chan.total_count     <= s1_total_ff;
         rsp_chan.turn_count      <= s1_turns_ff;
         rsp_chan.position_fix    <= pos_sat;
         rsp_chan.speed_fix       <=
            s1_spd_prod_ff[mfmd_pkg::FRAC_W+mfmd_pkg::WORD_W-1:mfmd_pkg::FRAC_W];
         rsp_chan.torque_fix      <=
            s1_trq_prod_ff[mfmd_pkg::FRAC_W+mfmd_pkg::WORD_W-1:mfmd_pkg::FRAC_W];
         rsp_chan.temperature_out <= s1_temp_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;

endmodule
`default_nettype wire

// ===== hdl/motor_feedback_multiturn_decoder.sv =====
// Multi-turn feedback decoder top level: register file, front end, queue, back end.
// An accepted word passes the queue, the product stage and the result word register.
// Throughput: one word per cycle while the queue has room; the front-end unwrap and the
// back-end product stage each take one word a cycle; the queue absorbs result-side stalls.
// Reset (synchronous): clears gains, offset, turn count, previous angle, queue and stages.
`default_nettype none
module motor_feedback_multiturn_decoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   mfmd_req_if.sink                                    req_chan,
   mfmd_rsp_if.source                                  rsp_chan,
   input  wire logic                                   csr_write_en,
   input  wire logic [mfmd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [mfmd_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   logic signed [mfmd_pkg::OFFSET_W-1:0]  offset_ff;
   mfmd_pkg::gains_type                   gains_ff;
   mfmd_pkg::queue_status_type            q_status;
   mfmd_pkg::entry_type                   push_entry;
   mfmd_pkg::entry_type                   pop_entry;
   logic                                  push;
   logic                                  pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         gains_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            mfmd_pkg::REG_COUNT_OFFSET:   offset_ff <= csr_write_data[mfmd_pkg::OFFSET_W-1:0];
            mfmd_pkg::REG_POSITION_GAIN:  gains_ff.position_gain <= csr_write_data;
            mfmd_pkg::REG_SPEED_GAIN:     gains_ff.speed_gain    <= csr_write_data;
            mfmd_pkg::REG_TORQUE_GAIN:    gains_ff.torque_gain   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // unwrap front end
   mfmd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .count_offset   (offset_ff),
      .q_status       (q_status),
      .push           (push),
      .push_entry     (push_entry)
   );

   // decoupling queue
   mfmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   // scaling back end
   mfmd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_entry (pop_entry),
      .gains     (gains_ff),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

   // no push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("queue written while full");

   // no pop from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue read while empty");

   // a word pushed into an empty queue is visible as not empty next cycle
   a_push_seen: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !q_status.empty)
      else $error("pushed word lost");

   // nothing is offered straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

endmodule
`default_nettype wire

// ===== dv/mfmd_tb_pkg.sv =====
// scoreboard package for the multi-turn feedback decoder: unwrap predictor and result checks
`timescale 1ns / 1ps
package mfmd_tb_pkg;
   import mfmd_pkg::*;

   localparam longint POSITION_HIGH = (longint'(1) <<< (POS_W - 1)) - 1;
   localparam longint POSITION_LOW  = -(longint'(1) <<< (POS_W - 1));

   // one feedback report as driven on the request channel
   typedef struct packed {
      logic [ANGLE_W-1:0]       rotor_angle;
      logic signed [RAW_W-1:0]  speed_rpm;
      logic signed [RAW_W-1:0]  current_raw;
      logic [TEMP_W-1:0]        temperature;
   } report_type;

   // one decoded word as seen on the result channel
   typedef struct packed {
      logic signed [WORD_W-1:0] total_count;
      logic signed [WORD_W-1:0] turn_count;
      logic signed [POS_W-1:0]  position_fix;
      logic signed [WORD_W-1:0] speed_fix;
      logic signed [WORD_W-1:0] torque_fix;
      logic [TEMP_W-1:0]        temperature;
   } decoded_type;

   class decode_tracker;
      // register copy
      logic signed [OFFSET_W-1:0] count_offset  = '0;
      logic [WORD_W-1:0]          position_gain = '0;
      logic [WORD_W-1:0]          speed_gain    = '0;
      logic [WORD_W-1:0]          torque_gain   = '0;
      // unwrap state
      logic [ANGLE_W-1:0]         last_angle    = '0;
      int                         turns         = 0;
      // decoded words still owed by the block
      decoded_type                due_words[$];
      int                         mismatches    = 0;
      int                         checked       = 0;
      int                         saturations   = 0;
      int                         total_wraps   = 0;
      int                         half_turns    = 0;

      function void set_register(logic [CSR_INDEX_W-1:0] reg_index,
                                 logic [CSR_DATA_W-1:0] data);
         case (reg_index)
            REG_COUNT_OFFSET:   count_offset  = data[OFFSET_W-1:0];
            REG_POSITION_GAIN:  position_gain = data;
            REG_SPEED_GAIN:     speed_gain    = data;
            REG_TORQUE_GAIN:    torque_gain   = data;
            default: ;
         endcase
      endfunction

      // floor(value * gain / 2^16)
      function longint scale_q16(longint value, logic [WORD_W-1:0] gain);
         return (value * longint'({{(64 - WORD_W){1'b0}}, gain})) >>> FRAC_W;
      endfunction

      // unwrap one accepted report and queue the word it must produce
      function void note_report(report_type r);
         int          delta;
         int          total;
         longint      exact;
         longint      pos;
         decoded_type d;
         delta = int'(r.rotor_angle) - int'(last_angle);
         if (delta < -HALF_TURN) turns++;
         else if (delta > HALF_TURN) turns--;
         if (delta == HALF_TURN || delta == -HALF_TURN) half_turns++;
         last_angle = r.rotor_angle;

         total = turns * COUNTS_PER_TURN + int'(r.rotor_angle) + int'(count_offset);
         exact = longint'(turns) * COUNTS_PER_TURN + longint'(r.rotor_angle)
                 + longint'(count_offset);
         if (exact != longint'(total)) total_wraps++;

         // position clamps to the 39 bit range
         pos = scale_q16(longint'(total), position_gain);
         if (pos > POSITION_HIGH) begin
            pos = POSITION_HIGH;
            saturations++;
         end else if (pos < POSITION_LOW) begin
            pos = POSITION_LOW;
            saturations++;
         end

         d.total_count  = total;
         d.turn_count   = turns;
         d.position_fix = pos[POS_W-1:0];
         d.speed_fix    = WORD_W'(scale_q16(longint'($signed(r.speed_rpm)), speed_gain));
         d.torque_fix   = WORD_W'(scale_q16(longint'($signed(r.current_raw)), torque_gain));
         d.temperature  = r.temperature;
         due_words.push_back(d);
      endfunction

      task report(string what);
         mismatches++;
         $display("mismatch: %s", what);
      endtask

      task compare_field(string field, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report($sformatf("word %0d %s: got %h, expected %h", checked, field, got, want));
      endtask

      // match an accepted word against the oldest one owed
      task check_result(decoded_type got);
         decoded_type want;
         if (due_words.size() == 0) begin
            report($sformatf("word %0d arrived with no report outstanding", checked));
            return;
         end
         want = due_words.pop_front();
         compare_field("total_count", got.total_count, want.total_count);
         compare_field("turn_count", got.turn_count, want.turn_count);
         compare_field("position_fix", got.position_fix, want.position_fix);
         compare_field("speed_fix", got.speed_fix, want.speed_fix);
         compare_field("torque_fix", got.torque_fix, want.torque_fix);
         compare_field("temperature_out", got.temperature, want.temperature);
         checked++;
      endtask
   endclass

endpackage

// ===== dv/motor_feedback_multiturn_decoder_tb.sv =====
// testbench top for the multi-turn feedback decoder: stimulus, handshakes and verdict
`timescale 1ns / 1ps
module motor_feedback_multiturn_decoder_tb;
   import mfmd_pkg::*;
   import mfmd_tb_pkg::*;

   localparam int     CLOCK_HALF    = 5;
   localparam int     RESET_CYCLES  = 12;
   localparam int     SETTLE_CYCLES = 6;
   localparam longint CYCLE_LIMIT   = 2_500_000;
   // reports in the closing forward spin
   localparam int     SPIN_REPORTS  = 60;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   csr_write_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   logic                   rx_hold        = 1'b0;
   int                     send_idle_pct  = 0;
   int                     stall_pct      = 0;
   int                     settings_count = 0;
   longint                 cycles         = 0;
   logic [ANGLE_W-1:0]     shaft_angle    = '0;

   int directed_angles [20] = '{5000, 0, 4096, 0, 4097, 0, 8191, 0, 8191, 8191,
                                4095, 0, 4095, 8190, 4093, 8188, 4092, 1, 4097, 8191};

   decode_tracker tracker = new;

   mfmd_req_if req_chan();
   mfmd_rsp_if rsp_chan();

   motor_feedback_multiturn_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // clock
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still owed", cycles,
                  tracker.due_words.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic decoded_type rsp_word();
      decoded_type w;
      w.total_count  = rsp_chan.total_count;
      w.turn_count   = rsp_chan.turn_count;
      w.position_fix = rsp_chan.position_fix;
      w.speed_fix    = rsp_chan.speed_fix;
      w.torque_fix   = rsp_chan.torque_fix;
      w.temperature  = rsp_chan.temperature_out;
      return w;
   endfunction

   // result side: check accepted words, then pick next ready
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) tracker.check_result(rsp_word());
         rsp_chan.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [RAW_W-1:0] raw_extreme(input int pick);
      case (pick % 5)
         0:       return {1'b0, {(RAW_W - 1){1'b1}}};
         1:       return {1'b1, {(RAW_W - 1){1'b0}}};
         2:       return '0;
         3:       return '1;
         default: return RAW_W'(1);
      endcase
   endfunction

   function automatic logic [RAW_W-1:0] raw_value();
      if ($urandom_range(9) == 0) return raw_extreme($urandom_range(4));
      return RAW_W'($urandom);
   endfunction

   function automatic report_type make_report(input logic [ANGLE_W-1:0] angle);
      report_type r;
      r.rotor_angle = angle;
      r.speed_rpm   = raw_value();
      r.current_raw = raw_value();
      r.temperature = TEMP_W'($urandom);
      return r;
   endfunction

   // offset register with junk above its 17 bits
   function automatic logic [CSR_DATA_W-1:0] offset_word(input logic [OFFSET_W-1:0] v);
      return {(CSR_DATA_W - OFFSET_W)'($urandom), v};
   endfunction

   // write all four registers on consecutive edges
   task automatic configure(input logic [CSR_DATA_W-1:0] off, pgain, sgain, tgain);
      logic [CSR_INDEX_W-1:0] regs [4];
      logic [CSR_DATA_W-1:0]  values [4];
      regs   = '{REG_COUNT_OFFSET, REG_POSITION_GAIN, REG_SPEED_GAIN, REG_TORQUE_GAIN};
      values = '{off, pgain, sgain, tgain};
      for (int i = 0; i < 4; i++) begin
         csr_write_en   <= 1'b1;
         csr_index      <= regs[i];
         csr_write_data <= values[i];
         @(posedge clock);
         tracker.set_register(regs[i], values[i]);
      end
      csr_write_en <= 1'b0;
      settings_count++;
   endtask

   // wait until every owed word is back and the pipeline is quiet
   task automatic settle();
      while (tracker.due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // offer one report, idling first at random, until it is taken
   task automatic send_report(input report_type r);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.rotor_angle    <= r.rotor_angle;
      req_chan.speed_rpm      <= r.speed_rpm;
      req_chan.current_raw    <= r.current_raw;
      req_chan.temperature_in <= r.temperature;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_report(r);
      shaft_angle = r.rotor_angle;
   endtask

   // long receiver hold-off so the block backs up into its input
   task automatic hold_receiver(input int hold_cycles);
      if (hold_cycles == 0) return;
      rx_hold <= 1'b1;
      repeat (hold_cycles) @(posedge clock);
      rx_hold <= 1'b0;
   endtask

   // runs of steady rotation at random rates, with some scrambled angles
   task automatic run_random(input int count);
      int run_left = 0;
      int stride   = 0;
      bit jumble   = 1'b0;
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(24, 3);
            jumble   = ($urandom_range(99) < 15);
            case ($urandom_range(3))
               0:       stride = int'($urandom_range(400)) - 200;
               1:       stride = int'($urandom_range(2 * HALF_TURN - 2)) - (HALF_TURN - 1);
               2:       stride = $urandom_range(1) ? HALF_TURN : -HALF_TURN;
               default: stride = int'($urandom_range(2 * HALF_TURN + 400)) - HALF_TURN - 200;
            endcase
         end
         run_left--;
         if (jumble) shaft_angle = ANGLE_W'($urandom);
         else shaft_angle = shaft_angle + ANGLE_W'(stride + int'($urandom_range(6)) - 3);
         send_report(make_report(shaft_angle));
      end
   endtask

   task automatic run_phase(input int idle, stall, hold_cycles, count,
                            input logic [CSR_DATA_W-1:0] off, pgain, sgain, tgain);
      settle();
      configure(off, pgain, sgain, tgain);
      send_idle_pct = idle;
      stall_pct     = stall;
      fork
         hold_receiver(hold_cycles);
         run_random(count);
      join
      req_chan.valid <= 1'b0;
   endtask

   // main sequence
   initial begin
      report_type r;
      req_chan.valid          = 1'b0;
      req_chan.rotor_angle    = '0;
      req_chan.speed_rpm      = '0;
      req_chan.current_raw    = '0;
      req_chan.temperature_in = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: half-turn boundaries, first report, field extremes, full gains
      configure(offset_word({1'b0, {(OFFSET_W - 1){1'b1}}}), '1, '1, '1);
      for (int i = 0; i < 20; i++) begin
         r.rotor_angle = ANGLE_W'(directed_angles[i]);
         r.speed_rpm   = raw_extreme(i);
         r.current_raw = raw_extreme(i + 2);
         r.temperature = TEMP_W'(i * 85);
         send_report(r);
      end
      req_chan.valid <= 1'b0;

      // random phases over idle patterns and register settings
      run_phase(0, 0, 0, 150, offset_word({1'b1, {(OFFSET_W - 1){1'b0}}}), '0, '0, '0);
      run_phase(70, 0, 0, 350, offset_word(OFFSET_W'($urandom)), $urandom, $urandom,
                $urandom);
      run_phase(0, 70, 400, 350, offset_word(OFFSET_W'($urandom)), $urandom_range(65535),
                $urandom_range(65535), $urandom_range(65535));
      run_phase(14, 14, 0, 350, offset_word(OFFSET_W'($urandom)), $urandom, $urandom,
                $urandom);

      // steady forward spin under large gains, turn count climbing each few words
      settle();
      configure(offset_word(OFFSET_W'($urandom)), {1'b1, 31'($urandom)}, $urandom, $urandom);
      send_idle_pct = 0;
      stall_pct     = 0;
      for (int n = 0; n < SPIN_REPORTS; n++) begin
         shaft_angle = shaft_angle + ANGLE_W'($urandom_range(HALF_TURN - 1, HALF_TURN - 96));
         send_report(make_report(shaft_angle));
      end
      req_chan.valid <= 1'b0;

      settle();
      $display("checked %0d decoded words over %0d register settings, %0d exact half turns",
               tracker.checked, settings_count, tracker.half_turns);
      $display("%0d saturated positions, %0d wrapped totals, final turn count %0d",
               tracker.saturations, tracker.total_wraps, tracker.turns);
      if (tracker.mismatches == 0 && tracker.due_words.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
